// ===== rtl/dmpm_pkg.sv =====
// Shared types and constants for the differential motor power mapper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dmpm_pkg;

   // PWM counter full scale; a compare value never exceeds it.
   localparam int PWM_FULL_SCALE_I = 999;
   localparam logic [15:0] PWM_FULL_SCALE = 16'(PWM_FULL_SCALE_I);

   // Q2.14 unity and the clamp window for the wheel gains.
   localparam logic [14:0] ONE_Q14  = 15'd16384;
   localparam logic [14:0] SCALE_LO = 15'd8192;
   localparam logic [14:0] SCALE_HI = 15'd24576;

   // Configuration port address width (four word registers).
   localparam int CSR_ADDR_W = 4;

   // Speed count to power conversion: floor(c * 2^14 / PWM_FULL_SCALE) done as a
   // multiply by a rounded-up reciprocal. Only counts up to the full scale need an
   // exact quotient; anything larger ends up capped at unity further down.
   localparam int SPD_CBITS = $clog2(PWM_FULL_SCALE_I + 1);
   localparam int SPD_NBITS = SPD_CBITS + 14;
   localparam int SPD_LBITS = $clog2(PWM_FULL_SCALE_I);
   localparam int SPD_SHIFT = SPD_NBITS + SPD_LBITS - 14;
   localparam longint unsigned SPD_RECIP_L =
      ((64'd1 << (SPD_NBITS + SPD_LBITS)) + 64'(PWM_FULL_SCALE_I) - 64'd1) /
      64'(PWM_FULL_SCALE_I);
   localparam logic [SPD_NBITS:0] SPD_RECIP = (SPD_NBITS + 1)'(SPD_RECIP_L);
   localparam int SPD_PROD_W = SPD_CBITS + SPD_NBITS + 1;
   // Marker for a converted power above unity.
   localparam logic [14:0] SPD_OVER = ONE_Q14 + 15'd1;

   // Compare arithmetic widths.
   localparam int PROD1_W   = 30;
   localparam int PROD2_W   = PROD1_W + 16;
   localparam int CMP_SHIFT = 28;

   typedef enum logic [2:0] {
      MODE_POWER = 3'd0,
      MODE_DIFF  = 3'd1,
      MODE_SPEED = 3'd2,
      MODE_STOP  = 3'd3,
      MODE_BRAKE = 3'd4
   } mode_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] left_command;
      logic signed [15:0] right_command;
   } cmd_type;

   typedef struct packed {
      logic [14:0] left_scale;
      logic [14:0] right_scale;
      logic [14:0] min_start_power;
      logic [14:0] min_turn_power;
   } cfg_type;

   // Wheel powers after mode handling, both within 0..unity.
   typedef struct packed {
      logic [14:0] left_power;
      logic [14:0] right_power;
      logic        left_fwd;
      logic        right_fwd;
      logic        brake;
   } shaped_type;

   typedef struct packed {
      logic [15:0] left_compare;
      logic [15:0] right_compare;
      logic        left_pin_a;
      logic        left_pin_b;
      logic        right_pin_a;
      logic        right_pin_b;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/dmpm_csr.sv =====
// Configuration registers of the motor power mapper behind an APB-style port.
// Depends on dmpm_pkg for the register widths and the gain clamp window.
`default_nettype none

module dmpm_csr
   import dmpm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output cfg_type                    cfg
);

   typedef enum logic [1:0] {
      REG_LEFT_SCALE  = 2'd0,
      REG_RIGHT_SCALE = 2'd1,
      REG_MIN_START   = 2'd2,
      REG_MIN_TURN    = 2'd3
   } reg_index_type;

   cfg_type       cfg_ff, cfg_in;
   logic [14:0]   wval;
   logic [14:0]   wscale;
   logic          wr;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;
   assign wval   = pwdata[14:0];
   assign wscale = (wval < SCALE_LO) ? SCALE_LO : ((wval > SCALE_HI) ? SCALE_HI : wval);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_LEFT_SCALE:  cfg_in.left_scale      = wscale;
            REG_RIGHT_SCALE: cfg_in.right_scale     = wscale;
            REG_MIN_START:   cfg_in.min_start_power = wval;
            REG_MIN_TURN:    cfg_in.min_turn_power  = wval;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_scale      <= ONE_Q14;
         cfg_ff.right_scale     <= ONE_Q14;
         cfg_ff.min_start_power <= '0;
         cfg_ff.min_turn_power  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_LEFT_SCALE:  prdata = {17'd0, cfg_ff.left_scale};
         REG_RIGHT_SCALE: prdata = {17'd0, cfg_ff.right_scale};
         REG_MIN_START:   prdata = {17'd0, cfg_ff.min_start_power};
         REG_MIN_TURN:    prdata = {17'd0, cfg_ff.min_turn_power};
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/dmpm_front.sv =====
// Front half of the mapper pipeline: request capture, speed count conversion
// and per-mode shaping of the two wheel powers. Depends on dmpm_pkg.
`default_nettype none

module dmpm_front
   import dmpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_cmd,
   input  wire cfg_type cfg,
   output logic         out_valid,
   input  wire logic    out_ready,
   output shaped_type   out_data
);

   // Caps a power at unity.
   function automatic logic [14:0] cap_one(input logic [15:0] v);
      logic [14:0] res;
      res = (v > {1'b0, ONE_Q14}) ? ONE_Q14 : v[14:0];
      return res;
   endfunction

   // Raises a positive power to a floor, then caps it at unity.
   function automatic logic [14:0] floor_cap(input logic [14:0] p, input logic [14:0] lo);
      logic [14:0] t;
      t = (p < lo) ? lo : p;
      return cap_one({1'b0, t});
   endfunction

   // Speed counts to Q2.14 power; zero means no forward drive.
   function automatic logic [14:0] spd_power(input logic signed [15:0] c);
      logic [SPD_PROD_W-1:0] prod;
      logic [14:0]           q;
      logic [14:0]           res;
      prod = SPD_PROD_W'(c[SPD_CBITS-1:0]) * SPD_PROD_W'(SPD_RECIP);
      q    = prod[SPD_SHIFT +: 15];
      if (c[15] || c == 16'sd0) begin
         res = '0;
      end else if ({1'b0, c[14:0]} > PWM_FULL_SCALE) begin
         res = SPD_OVER;
      end else if (q == 15'd0) begin
         res = 15'd1;
      end else begin
         res = q;
      end
      return res;
   endfunction

   // Stage A: captured request.
   logic        a_v_ff, a_v_in, a_rdy;
   cmd_type     a_cmd_ff;
   // Stage B: request plus converted speed powers.
   logic        b_v_ff, b_v_in, b_rdy;
   cmd_type     b_cmd_ff;
   logic [14:0] b_spd_l_ff, b_spd_l_in, b_spd_r_ff, b_spd_r_in;
   // Stage C: shaped wheel powers.
   logic        c_v_ff, c_v_in, c_rdy;
   shaped_type  c_out_ff, c_out_in;

   // Shaping terms.
   logic        l_pos, r_pos;
   logic [14:0] lu, ru, lo, boost;
   logic [14:0] l_plain, r_plain, l_spd, r_spd, l_diff, r_diff;

   assign c_rdy    = !c_v_ff || out_ready;
   assign b_rdy    = !b_v_ff || c_rdy;
   assign a_rdy    = !a_v_ff || b_rdy;
   assign in_ready = a_rdy;

   assign a_v_in = a_rdy ? in_valid : a_v_ff;
   assign b_v_in = b_rdy ? a_v_ff : b_v_ff;
   assign c_v_in = c_rdy ? b_v_ff : c_v_ff;

   assign b_spd_l_in = spd_power(a_cmd_ff.left_command);
   assign b_spd_r_in = spd_power(a_cmd_ff.right_command);

   always_comb begin
      l_pos = !b_cmd_ff.left_command[15] && (b_cmd_ff.left_command != 16'sd0);
      r_pos = !b_cmd_ff.right_command[15] && (b_cmd_ff.right_command != 16'sd0);
      lu    = b_cmd_ff.left_command[14:0];
      ru    = b_cmd_ff.right_command[14:0];
      lo    = (lu < ru) ? lu : ru;
      boost = (lo < cfg.min_start_power) ? (cfg.min_start_power - lo) : 15'd0;

      l_plain = floor_cap(lu, cfg.min_start_power);
      r_plain = floor_cap(ru, cfg.min_start_power);
      l_spd   = floor_cap(b_spd_l_ff, cfg.min_start_power);
      r_spd   = floor_cap(b_spd_r_ff, cfg.min_start_power);

      // With both wheels forward the common boost applies; in a pivot the
      // moving wheel is raised to the turn minimum instead.
      l_diff = r_pos ? cap_one({1'b0, lu} + {1'b0, boost})
                     : floor_cap(lu, cfg.min_turn_power);
      r_diff = l_pos ? cap_one({1'b0, ru} + {1'b0, boost})
                     : floor_cap(ru, cfg.min_turn_power);

      c_out_in = '0;
      case (b_cmd_ff.mode)
         MODE_POWER: begin
            c_out_in.left_power  = l_pos ? l_plain : 15'd0;
            c_out_in.right_power = r_pos ? r_plain : 15'd0;
            c_out_in.left_fwd    = l_pos;
            c_out_in.right_fwd   = r_pos;
         end
         MODE_DIFF: begin
            c_out_in.left_power  = l_pos ? l_diff : 15'd0;
            c_out_in.right_power = r_pos ? r_diff : 15'd0;
            c_out_in.left_fwd    = l_pos;
            c_out_in.right_fwd   = r_pos;
         end
         MODE_SPEED: begin
            c_out_in.left_power  = (b_spd_l_ff != 15'd0) ? l_spd : 15'd0;
            c_out_in.right_power = (b_spd_r_ff != 15'd0) ? r_spd : 15'd0;
            c_out_in.left_fwd    = (b_spd_l_ff != 15'd0);
            c_out_in.right_fwd   = (b_spd_r_ff != 15'd0);
         end
         MODE_BRAKE: begin
            c_out_in.brake = 1'b1;
         end
         default: begin
            c_out_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && in_valid) begin
         a_cmd_ff <= in_cmd;
      end
      if (b_rdy && a_v_ff) begin
         b_cmd_ff   <= a_cmd_ff;
         b_spd_l_ff <= b_spd_l_in;
         b_spd_r_ff <= b_spd_r_in;
      end
      if (c_rdy && b_v_ff) begin
         c_out_ff <= c_out_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_data  = c_out_ff;

endmodule

`default_nettype wire

// ===== rtl/dmpm_back.sv =====
// Back half of the mapper pipeline: gain multiply, full-scale multiply and the
// registered result with saturation and bridge pin levels. Depends on dmpm_pkg.
`default_nettype none

module dmpm_back
   import dmpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire shaped_type in_data,
   input  wire cfg_type    cfg,
   output logic            out_valid,
   input  wire logic       out_ready,
   output rsp_type         out_data
);

   typedef struct packed {
      logic left_fwd;
      logic right_fwd;
      logic brake;
   } flags_type;

   // Stage D: power times gain.
   logic               d_v_ff, d_v_in, d_rdy;
   logic [PROD1_W-1:0] d_l_ff, d_l_in, d_r_ff, d_r_in;
   flags_type          d_f_ff;
   // Stage E: times the PWM full scale.
   logic               e_v_ff, e_v_in, e_rdy;
   logic [PROD2_W-1:0] e_l_ff, e_l_in, e_r_ff, e_r_in;
   flags_type          e_f_ff;
   // Stage F: output register.
   logic               f_v_ff, f_v_in, f_rdy;
   rsp_type            f_out_ff, f_out_in;

   logic [PROD2_W-CMP_SHIFT-1:0] l_raw, r_raw;
   logic [15:0]                  l_cmp, r_cmp;

   assign f_rdy    = !f_v_ff || out_ready;
   assign e_rdy    = !e_v_ff || f_rdy;
   assign d_rdy    = !d_v_ff || e_rdy;
   assign in_ready = d_rdy;

   assign d_v_in = d_rdy ? in_valid : d_v_ff;
   assign e_v_in = e_rdy ? d_v_ff : e_v_ff;
   assign f_v_in = f_rdy ? e_v_ff : f_v_ff;

   assign d_l_in = PROD1_W'(in_data.left_power) * PROD1_W'(cfg.left_scale);
   assign d_r_in = PROD1_W'(in_data.right_power) * PROD1_W'(cfg.right_scale);

   assign e_l_in = PROD2_W'(d_l_ff) * PROD2_W'(PWM_FULL_SCALE);
   assign e_r_in = PROD2_W'(d_r_ff) * PROD2_W'(PWM_FULL_SCALE);

   assign l_raw = e_l_ff[PROD2_W-1:CMP_SHIFT];
   assign r_raw = e_r_ff[PROD2_W-1:CMP_SHIFT];
   assign l_cmp = (l_raw > (PROD2_W-CMP_SHIFT)'(PWM_FULL_SCALE)) ? PWM_FULL_SCALE : l_raw[15:0];
   assign r_cmp = (r_raw > (PROD2_W-CMP_SHIFT)'(PWM_FULL_SCALE)) ? PWM_FULL_SCALE : r_raw[15:0];

   always_comb begin
      f_out_in.left_compare  = e_f_ff.brake ? PWM_FULL_SCALE : l_cmp;
      f_out_in.right_compare = e_f_ff.brake ? PWM_FULL_SCALE : r_cmp;
      f_out_in.left_pin_a    = e_f_ff.brake || e_f_ff.left_fwd;
      f_out_in.left_pin_b    = e_f_ff.brake;
      f_out_in.right_pin_a   = e_f_ff.brake;
      f_out_in.right_pin_b   = e_f_ff.brake || e_f_ff.right_fwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         d_v_ff <= d_v_in;
         e_v_ff <= e_v_in;
         f_v_ff <= f_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (d_rdy && in_valid) begin
         d_l_ff           <= d_l_in;
         d_r_ff           <= d_r_in;
         d_f_ff.left_fwd  <= in_data.left_fwd;
         d_f_ff.right_fwd <= in_data.right_fwd;
         d_f_ff.brake     <= in_data.brake;
      end
      if (e_rdy && d_v_ff) begin
         e_l_ff <= e_l_in;
         e_r_ff <= e_r_in;
         e_f_ff <= d_f_ff;
      end
      if (f_rdy && e_v_ff) begin
         f_out_ff <= f_out_in;
      end
   end

   assign out_valid = f_v_ff;
   assign out_data  = f_out_ff;

endmodule

`default_nettype wire

// ===== rtl/differential_motor_power_mapper.sv =====
// Differential motor power mapper, top level: stream ports, APB-style register
// port. Depends on dmpm_pkg, dmpm_csr, dmpm_front and dmpm_back.
`default_nettype none

// Each request carries a mode in tuser and two signed Q2.14 wheel commands (or
// signed speed counts) in tdata, and yields exactly one response with the two
// PWM compare values and the four H-bridge pin levels. The block is a
// six-stage pipeline: capture, speed conversion, mode shaping, gain multiply,
// full-scale multiply, and the output register. It takes one request in every
// clock cycle while the response side is not stalled. Every stage holds its
// own valid bit, so a stalled response only holds back the stages behind it
// and empty stages keep filling. Registers are written through the APB-style
// port with a setup and an access phase; pready is always high and reads
// return the stored value (gains already clamped to 0.5..1.5). Registers
// should be written only while no request is in flight.

module differential_motor_power_mapper
   import dmpm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] left_command, [31:16] right_command
   input  wire logic [31:0]           req_tdata,
   // [2:0] mode
   input  wire logic [2:0]            req_tuser,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] left_compare, [31:16] right_compare, [32] left_pin_a,
   // [33] left_pin_b, [34] right_pin_a, [35] right_pin_b, [39:36] zero
   output logic [39:0]                rsp_tdata,
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   logic       mid_valid, mid_ready;
   shaped_type mid_data;
   rsp_type    rsp;

   assign csr_pready = 1'b1;

   dmpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign cmd.mode          = req_tuser;
   assign cmd.left_command  = req_tdata[15:0];
   assign cmd.right_command = req_tdata[31:16];

   // Capture, speed conversion and mode shaping.
   dmpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (cmd),
      .cfg       (cfg),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // Compare arithmetic and the output register.
   dmpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.right_pin_b, rsp.right_pin_a, rsp.left_pin_b,
                       rsp.left_pin_a, rsp.right_compare, rsp.left_compare};

endmodule

`default_nettype wire

// ===== rtl/dmpm_checker.sv =====
// Port-level checks for the differential motor power mapper, bound to the top.
// Depends on dmpm_pkg for the PWM full scale.
`default_nettype none

module dmpm_checker
   import dmpm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Compares never exceed the PWM full scale.
   a_compare_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] <= PWM_FULL_SCALE) &&
                     (rsp_tdata[31:16] <= PWM_FULL_SCALE))
      else $error("compare above full scale");

   // Braking drives all four pins and full-scale compares.
   a_brake_pattern: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33]) |-> rsp_tdata[32] && rsp_tdata[34] && rsp_tdata[35] &&
         (rsp_tdata[15:0] == PWM_FULL_SCALE) && (rsp_tdata[31:16] == PWM_FULL_SCALE))
      else $error("inconsistent brake response");

   // A coasting wheel has a zero compare.
   a_coast_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32] || (rsp_tdata[15:0] == 16'd0)) &&
                     (rsp_tdata[35] || (rsp_tdata[31:16] == 16'd0)))
      else $error("coasting wheel with nonzero compare");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind differential_motor_power_mapper dmpm_checker u_dmpm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
